// ----- rtl/core/kpc_pkg.sv -----
// Shared types, register codes and reset thresholds of the key press classifier.
package kpc_pkg;

   localparam int unsigned KeyWidth    = 6;
   localparam int unsigned TickWidth   = 8;
   localparam int unsigned AddrWidth   = 4;
   localparam int unsigned DataWidth   = 32;

   localparam logic [TickWidth-1:0] DebounceReset       = 8'd5;
   localparam logic [TickWidth-1:0] LongPressReset      = 8'd80;
   localparam logic [TickWidth-1:0] RepeatDelayReset    = 8'd100;
   localparam logic [TickWidth-1:0] RepeatIntervalReset = 8'd20;

   typedef enum logic [1:0] {
      REG_DEBOUNCE        = 2'd0,
      REG_LONG_PRESS      = 2'd1,
      REG_REPEAT_DELAY    = 2'd2,
      REG_REPEAT_INTERVAL = 2'd3
   } reg_index_type;

   typedef enum logic [1:0] {
      KIND_NONE   = 2'd0,
      KIND_NORMAL = 2'd1,
      KIND_LONG   = 2'd2,
      KIND_REPEAT = 2'd3
   } kind_type;

   typedef enum logic [4:0] {
      PHASE_START  = 5'b00001,
      PHASE_PRESS  = 5'b00010,
      PHASE_LONG   = 5'b00100,
      PHASE_DELAY  = 5'b01000,
      PHASE_REPEAT = 5'b10000
   } phase_type;

   typedef struct packed {
      logic [TickWidth-1:0] debounce_ticks;
      logic [TickWidth-1:0] long_press_ticks;
      logic [TickWidth-1:0] repeat_delay_ticks;
      logic [TickWidth-1:0] repeat_interval_ticks;
   } cfg_type;

endpackage

// ----- rtl/core/kpc_csr.sv -----
// Threshold register file behind the APB-style configuration port.
module kpc_csr (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          psel,
   input  logic                          penable,
   input  logic                          pwrite,
   input  logic [kpc_pkg::AddrWidth-1:0] paddr,
   input  logic [kpc_pkg::DataWidth-1:0] pwdata,
   output logic [kpc_pkg::DataWidth-1:0] prdata,
   output logic                          pready,
   output kpc_pkg::cfg_type              cfg
);
   import kpc_pkg::*;

   cfg_type       cfg_ff;
   cfg_type       cfg_in;
   reg_index_type index;
   logic          wr_en;
   logic [TickWidth-1:0] rd_value;

   assign pready = 1'b1;
   assign index  = reg_index_type'(paddr[AddrWidth-1:2]);
   assign wr_en  = psel & penable & pwrite & pready;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         unique case (index)
            REG_DEBOUNCE:        cfg_in.debounce_ticks        = pwdata[TickWidth-1:0];
            REG_LONG_PRESS:      cfg_in.long_press_ticks      = pwdata[TickWidth-1:0];
            REG_REPEAT_DELAY:    cfg_in.repeat_delay_ticks    = pwdata[TickWidth-1:0];
            REG_REPEAT_INTERVAL: cfg_in.repeat_interval_ticks = pwdata[TickWidth-1:0];
            default:             cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      unique case (index)
         REG_DEBOUNCE:        rd_value = cfg_ff.debounce_ticks;
         REG_LONG_PRESS:      rd_value = cfg_ff.long_press_ticks;
         REG_REPEAT_DELAY:    rd_value = cfg_ff.repeat_delay_ticks;
         REG_REPEAT_INTERVAL: rd_value = cfg_ff.repeat_interval_ticks;
         default:             rd_value = '0;
      endcase
   end

   assign prdata = {{(DataWidth-TickWidth){1'b0}}, rd_value};

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.debounce_ticks        <= DebounceReset;
         cfg_ff.long_press_ticks      <= LongPressReset;
         cfg_ff.repeat_delay_ticks    <= RepeatDelayReset;
         cfg_ff.repeat_interval_ticks <= RepeatIntervalReset;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

// ----- rtl/core/kpc_classify.sv -----
// Phase machine, hold counter and result register of the key press classifier.
module kpc_classify (
   input  logic                         clock,
   input  logic                         reset,
   input  kpc_pkg::cfg_type             cfg,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  logic [kpc_pkg::KeyWidth-1:0] req_key_code,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic [kpc_pkg::KeyWidth-1:0] rsp_report_key,
   output logic [1:0]                   rsp_report_kind
);
   import kpc_pkg::*;

   phase_type             phase_ff;
   phase_type             phase_in;
   logic [KeyWidth-1:0]   prev_key_ff;
   logic [KeyWidth-1:0]   prev_key_in;
   logic [TickWidth-1:0]  tick_ff;
   logic [TickWidth-1:0]  tick_in;
   logic                  rsp_valid_ff;
   logic                  rsp_valid_in;
   logic [KeyWidth-1:0]   report_key_ff;
   logic [KeyWidth-1:0]   report_key_in;
   kind_type              report_kind_ff;
   kind_type              report_kind_in;

   logic                  req_fire;
   logic                  match;
   logic                  hit;
   logic [TickWidth-1:0]  tick_inc;
   logic [TickWidth-1:0]  threshold;
   kind_type              phase_kind;
   phase_type             phase_next;

   assign req_ready = ~rsp_valid_ff | rsp_ready;
   assign req_fire  = req_valid & req_ready;

   always_comb begin
      unique case (phase_ff)
         PHASE_PRESS: begin
            threshold  = cfg.debounce_ticks;
            phase_kind = KIND_NORMAL;
            phase_next = PHASE_LONG;
         end
         PHASE_LONG: begin
            threshold  = cfg.long_press_ticks;
            phase_kind = KIND_LONG;
            phase_next = PHASE_DELAY;
         end
         PHASE_DELAY: begin
            threshold  = cfg.repeat_delay_ticks;
            phase_kind = KIND_NONE;
            phase_next = PHASE_REPEAT;
         end
         PHASE_REPEAT: begin
            threshold  = cfg.repeat_interval_ticks;
            phase_kind = KIND_REPEAT;
            phase_next = PHASE_REPEAT;
         end
         default: begin
            threshold  = '0;
            phase_kind = KIND_NONE;
            phase_next = PHASE_PRESS;
         end
      endcase
   end

   assign match    = (req_key_code != '0) && (req_key_code == prev_key_ff);
   assign tick_inc = tick_ff + TickWidth'(1);
   assign hit      = match && (tick_inc >= threshold);

   always_comb begin
      phase_in       = phase_ff;
      prev_key_in    = prev_key_ff;
      tick_in        = tick_ff;
      report_key_in  = '0;
      report_kind_in = KIND_NONE;
      if (match) begin
         tick_in = tick_inc;
         if (hit) begin
            tick_in        = '0;
            report_key_in  = req_key_code;
            report_kind_in = phase_kind;
            phase_in       = phase_next;
         end
      end else begin
         phase_in    = PHASE_START;
         prev_key_in = req_key_code;
      end
   end

   assign rsp_valid_in = req_fire | (rsp_valid_ff & ~rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PHASE_START;
         prev_key_ff  <= '0;
         tick_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (req_fire) begin
            phase_ff    <= phase_in;
            prev_key_ff <= prev_key_in;
            tick_ff     <= tick_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         report_key_ff  <= report_key_in;
         report_kind_ff <= report_kind_in;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_report_key  = report_key_ff;
   assign rsp_report_kind = report_kind_ff;

`ifndef NO_ASSERTIONS
   a_kind_has_key: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && report_kind_ff != KIND_NONE) |-> (report_key_ff != '0))
      else $error("classified report without a key");

   a_release_restarts: assert property (@(posedge clock) disable iff (reset)
      (req_fire && req_key_code == '0) |=> (prev_key_ff == '0 && phase_ff == PHASE_START))
      else $error("released key did not restart the phase machine");

   a_report_clears_tick: assert property (@(posedge clock) disable iff (reset)
      (req_fire && report_key_in != '0) |=> (tick_ff == '0))
      else $error("hold counter not cleared after a report");

   a_empty_takes_input: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid_ff |-> req_ready)
      else $error("empty result register blocks input");
`endif

endmodule

// ----- rtl/core/key_press_classifier_top.sv -----
// The result of an accepted transaction appears on the rsp_ channel in the cycle after it is accepted.
// Throughput: one transaction per cycle while rsp_ready is high; the result register frees on the cycle it is taken.
// Every accepted key code yields exactly one result (zero key and kind when no phase threshold is reached).
// Reset (synchronous, active high) restores the default thresholds 5, 80, 100 and 20,
// returns the phase machine to start and clears the latched key and hold counter.
module key_press_classifier_top (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [kpc_pkg::KeyWidth-1:0]  req_key_code,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [kpc_pkg::KeyWidth-1:0]  rsp_report_key,
   output logic [1:0]                    rsp_report_kind,
   input  logic                          psel,
   input  logic                          penable,
   input  logic                          pwrite,
   input  logic [kpc_pkg::AddrWidth-1:0] paddr,
   input  logic [kpc_pkg::DataWidth-1:0] pwdata,
   output logic [kpc_pkg::DataWidth-1:0] prdata,
   output logic                          pready
);
   import kpc_pkg::*;

   cfg_type cfg;

   kpc_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   kpc_classify u_classify (
      .clock           (clock),
      .reset           (reset),
      .cfg             (cfg),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_key_code    (req_key_code),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_report_key  (rsp_report_key),
      .rsp_report_kind (rsp_report_kind)
   );

endmodule
